// ===== design/sbn_pkg.sv =====
package sbn_pkg;

    typedef enum logic [2:0] {
        PH_PORT   = 3'd0,
        PH_RCLOCK = 3'd1,
        PH_INFO   = 3'd2,
        PH_NEG2M  = 3'd3,
        PH_NEG1M  = 3'd4,
        PH_RUN    = 3'd5,
        PH_HEALTH = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        OUT_PENDING = 2'd0,
        OUT_SUCCESS = 2'd1,
        OUT_FAILED  = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ACT_RC        = 3'd0,
        ACT_PING      = 3'd1,
        ACT_PROPOSE   = 3'd2,
        ACT_SWITCH    = 3'd3,
        ACT_RESETBAUD = 3'd4,
        ACT_INFO      = 3'd5,
        ACT_FALLBACK  = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        KIND_STEP     = 2'd0,
        KIND_RESPONSE = 2'd1,
        KIND_DEVINFO  = 2'd2,
        KIND_PING     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_PING_GAP   = 2'd0,
        REG_NEG_TMO    = 2'd1,
        REG_PROP_GAP   = 2'd2,
        REG_LIVE_TMO   = 2'd3
    } t_reg_idx;

    localparam int CFG_W     = 24;
    localparam int PING_GAP_W = 20;
    localparam logic [PING_GAP_W-1:0] PING_GAP_RST = 20'd20000;
    localparam logic [CFG_W-1:0]      NEG_TMO_RST  = 24'd1500000;
    localparam logic [CFG_W-1:0]      PROP_GAP_RST = 24'd500000;
    localparam logic [CFG_W-1:0]      LIVE_TMO_RST = 24'd500000;

    // one queue entry: the one or two results of an accepted item
    typedef struct packed {
        logic    two;
        t_action act0;
        logic    baud0;
        t_action act1;
        logic    baud1;
        t_phase  phase;
    } t_entry;

endpackage

// ===== design/serial_link_bringup_negotiator.sv =====
// Bring-up negotiator for a radio-control serial link. Each input beat is a
// timestamped event (tuser = kind: step tick, speed response, device info,
// device ping); the block steps through RC lock, device-info wait, 2M and
// then 1M baud negotiation, running and health check, and sends zero, one or
// two action beats per event, the final one flagged by tlast. Every action
// beat carries the phase reached after its event. Rate: one input beat is
// taken per cycle while the two-entry result queue has room; the output
// serializer sends one action beat per cycle while the sink is ready, and
// an event with two actions holds its queue entry until both are sent.
// Events that make no action never occupy the queue. Configuration writes
// take effect on the next cycle and must be made while no results are
// pending. No clearing pass after reset.
module serial_link_bringup_negotiator
    import sbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] now_us, [32] rx_active, [33] response_ok, [41:34] major_version
    input  logic [47:0]       s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [2:0] action, [3] baud_choice, [6:4] link_phase
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast
);

    logic   push, pop, full, q_valid;
    t_entry push_entry, head_entry;
    logic [2:0] out_action, out_phase;
    logic   out_baud;

    // front: event decode, phase state and timers
    sbn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_now      (s_axis_tdata[31:0]),
        .i_rx       (s_axis_tdata[32]),
        .i_ok       (s_axis_tdata[33]),
        .i_major    (s_axis_tdata[41:34]),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    sbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // back: one action beat per cycle while the sink is ready
    sbn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_entry  (head_entry),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_action (out_action),
        .o_baud   (out_baud),
        .o_phase  (out_phase),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_phase, out_baud, out_action};

    // a full queue always has a result to show
    a_full_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("queue full with no output beat");

    // the second result of an event follows the first
    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("second action beat lost");

    // baud choice only on propose and switch
    a_baud_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |->
            (m_axis_tdata[2:0] == ACT_PROPOSE || m_axis_tdata[2:0] == ACT_SWITCH))
        else $error("baud choice on wrong action");

    // port and unused phase codes are never reported
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:4] != PH_PORT && m_axis_tdata[6:4] != 3'd7))
        else $error("bad link phase");

endmodule

// ===== design/sbn_front.sv =====
module sbn_front
    import sbn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_kind,
    input  logic [31:0]       i_now,
    input  logic              i_rx,
    input  logic              i_ok,
    input  logic [7:0]        i_major,
    input  logic              i_full,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [PING_GAP_W-1:0] r_ping_gap;
    logic [CFG_W-1:0]      r_neg_tmo;
    logic [CFG_W-1:0]      r_prop_gap;
    logic [CFG_W-1:0]      r_live_tmo;

    t_phase   r_phase, n_phase;
    logic     r_target, n_target;
    t_outcome r_outcome, n_outcome;
    logic [31:0] r_neg_start, n_neg_start;
    logic [31:0] r_last_prop, n_last_prop;
    logic [31:0] r_last_ping, n_last_ping;
    logic [31:0] r_live_start, n_live_start;
    logic [7:0]  r_major, n_major;

    logic        accept;
    logic [31:0] start_eff;
    logic        ping_due, neg_expired, prop_due, live_expired;
    logic [1:0]  cnt;
    t_action     act [2];
    logic        baud [2];

    assign o_ready = ~i_full;
    assign accept  = i_valid & ~i_full;

    // independent compares, each one subtract and compare
    assign start_eff    = (r_neg_start == 32'd0) ? i_now : r_neg_start;
    assign ping_due     = (i_now - r_last_ping) >= {12'd0, r_ping_gap};
    assign neg_expired  = (i_now - start_eff) > {8'd0, r_neg_tmo};
    assign prop_due     = (i_now - r_last_prop) > {8'd0, r_prop_gap};
    assign live_expired = (i_now - r_live_start) > {8'd0, r_live_tmo};

    always_comb begin
        n_phase      = r_phase;
        n_target     = r_target;
        n_outcome    = r_outcome;
        n_neg_start  = r_neg_start;
        n_last_prop  = r_last_prop;
        n_last_ping  = r_last_ping;
        n_live_start = r_live_start;
        n_major      = r_major;
        cnt          = 2'd0;
        act[0]       = ACT_RC;
        act[1]       = ACT_RC;
        baud[0]      = 1'b0;
        baud[1]      = 1'b0;
        case (t_kind'(i_kind))
            KIND_STEP: begin
                case (r_phase)
                    PH_RCLOCK: begin
                        act[cnt[0]] = ACT_RC;
                        cnt = cnt + 2'd1;
                        if (i_rx) n_phase = PH_INFO;
                    end
                    PH_INFO: begin
                        if (ping_due) begin
                            n_last_ping = i_now;
                            act[cnt[0]] = ACT_PING;
                            cnt = cnt + 2'd1;
                        end
                        if (r_major != 8'd0 && i_rx) begin
                            n_phase   = PH_NEG2M;
                            n_target  = 1'b0;
                            n_outcome = OUT_PENDING;
                            act[cnt[0]] = ACT_RESETBAUD;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_NEG2M, PH_NEG1M: begin
                        if (ping_due) begin
                            n_last_ping = i_now;
                            act[cnt[0]] = ACT_PING;
                            cnt = cnt + 2'd1;
                        end
                        if (r_outcome == OUT_SUCCESS) begin
                            n_phase = PH_RUN;
                        end else begin
                            n_neg_start = start_eff;
                            if (r_outcome == OUT_FAILED || neg_expired) begin
                                if (r_phase == PH_NEG2M) begin
                                    // drop back to 1M negotiation
                                    n_phase     = PH_NEG1M;
                                    n_target    = 1'b1;
                                    n_outcome   = OUT_PENDING;
                                    n_last_prop = 32'd0;
                                    n_neg_start = 32'd0;
                                    act[cnt[0]] = ACT_RESETBAUD;
                                    cnt = cnt + 2'd1;
                                end else begin
                                    n_phase = PH_RUN;
                                    if (r_outcome == OUT_FAILED) begin
                                        act[cnt[0]] = ACT_FALLBACK;
                                        cnt = cnt + 2'd1;
                                    end
                                end
                            end else if (prop_due) begin
                                n_last_prop = i_now;
                                act[cnt[0]]  = ACT_PROPOSE;
                                baud[cnt[0]] = r_target;
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                    PH_RUN: begin
                        if (!i_rx) begin
                            n_live_start = i_now;
                            n_phase      = PH_HEALTH;
                            n_last_ping  = i_now;
                            act[cnt[0]]  = ACT_PING;
                            cnt = cnt + 2'd1;
                        end
                    end
                    PH_HEALTH: begin
                        if (i_rx) begin
                            n_phase = PH_RUN;
                        end else if (live_expired) begin
                            n_outcome = OUT_PENDING;
                            n_phase   = PH_RCLOCK;
                            act[cnt[0]] = ACT_RESETBAUD;
                            cnt = cnt + 2'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_RESPONSE: begin
                if (i_ok) begin
                    n_outcome = OUT_SUCCESS;
                    act[0]  = ACT_SWITCH;
                    baud[0] = r_target;
                    cnt = 2'd1;
                end else begin
                    n_outcome = OUT_FAILED;
                end
            end
            KIND_DEVINFO: begin
                n_major = i_major;
            end
            default: begin
                act[0] = ACT_INFO;
                cnt = 2'd1;
            end
        endcase
    end

    assign o_push        = accept & (cnt != 2'd0);
    assign o_entry.two   = cnt[1];
    assign o_entry.act0  = act[0];
    assign o_entry.baud0 = baud[0];
    assign o_entry.act1  = act[1];
    assign o_entry.baud1 = baud[1];
    assign o_entry.phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_gap <= PING_GAP_RST;
            r_neg_tmo  <= NEG_TMO_RST;
            r_prop_gap <= PROP_GAP_RST;
            r_live_tmo <= LIVE_TMO_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PING_GAP: r_ping_gap <= i_cfg_data[PING_GAP_W-1:0];
                REG_NEG_TMO:  r_neg_tmo  <= i_cfg_data;
                REG_PROP_GAP: r_prop_gap <= i_cfg_data;
                REG_LIVE_TMO: r_live_tmo <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_RCLOCK;
            r_target     <= 1'b0;
            r_outcome    <= OUT_PENDING;
            r_neg_start  <= 32'd0;
            r_last_prop  <= 32'd0;
            r_last_ping  <= 32'd0;
            r_live_start <= 32'd0;
            r_major      <= 8'd0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_target     <= n_target;
            r_outcome    <= n_outcome;
            r_neg_start  <= n_neg_start;
            r_last_prop  <= n_last_prop;
            r_last_ping  <= n_last_ping;
            r_live_start <= n_live_start;
            r_major      <= n_major;
        end
    end

endmodule

// ===== design/sbn_queue.sv =====
module sbn_queue
    import sbn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    // two-entry queue
    t_entry     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/sbn_back.sv =====
module sbn_back
    import sbn_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_entry i_entry,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output logic [2:0] o_action,
    output logic   o_baud,
    output logic [2:0] o_phase,
    output logic   o_last
);

    // which result of the head entry is on the bus
    logic r_beat;
    logic take;

    assign o_valid  = i_valid;
    assign o_action = r_beat ? i_entry.act1 : i_entry.act0;
    assign o_baud   = r_beat ? i_entry.baud1 : i_entry.baud0;
    assign o_phase  = i_entry.phase;
    assign o_last   = r_beat | ~i_entry.two;
    assign take     = i_valid & i_ready;
    assign o_pop    = take & o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= 1'b0;
        end else if (take) begin
            r_beat <= ~o_last;
        end
    end

endmodule
